[hw/rtl/vram_general_hblank_dma_unit_macros.svh]
// Assertion macros shared by the VRAM DMA unit.
// Plain text header; it depends on nothing else.
`ifndef VRAM_GENERAL_HBLANK_DMA_UNIT_MACROS_SVH
`define VRAM_GENERAL_HBLANK_DMA_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VHDMA_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VHDMA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/vhdma_pkg.sv]
// Types and constants for the VRAM DMA unit.
// Used by the front end, the job queue, the back end and the top level.
package vhdma_pkg;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_GENERAL = 2'd1,
        MODE_HBLANK  = 2'd2
    } t_mode;

    localparam logic       ACT_WRITE = 1'b0;
    localparam logic       ACT_STEP  = 1'b1;

    localparam logic [2:0] SEL_SRC_HI  = 3'd0;
    localparam logic [2:0] SEL_SRC_LO  = 3'd1;
    localparam logic [2:0] SEL_DST_HI  = 3'd2;
    localparam logic [2:0] SEL_DST_LO  = 3'd3;
    localparam logic [2:0] SEL_CONTROL = 3'd4;

    // Line tracker codes: nothing served yet, and a burst served with the display off.
    localparam logic [8:0] LINE_NONE     = 9'h1FF;
    localparam logic [8:0] LINE_LCD_OFF  = 9'h1FE;
    // Control readback while no copy is running.
    localparam logic [7:0] READBACK_IDLE = 8'hFF;

    localparam int unsigned BLOCK_BYTES = 16;
    localparam int unsigned BEAT_W      = $clog2(BLOCK_BYTES);

    localparam int unsigned IN_TDATA_W  = 24;
    localparam int unsigned IN_TUSER_W  = 4;
    localparam int unsigned OUT_TDATA_W = 48;
    localparam int unsigned OUT_TUSER_W = 3;

    // One queue entry: what the back end must emit for one accepted item.
    typedef struct packed {
        logic        copy_valid;
        logic        burst;
        logic [15:0] src;
        logic [12:0] dst;
        logic [7:0]  status;
        t_mode       mode;
        logic [6:0]  clocks;
    } t_job;

endpackage

[hw/rtl/vhdma_front.sv]
// Front end of the VRAM DMA unit: register file, copy state and item classification.
// Depends on vhdma_pkg; feeds t_job entries to the job queue.
module vhdma_front
    import vhdma_pkg::*;
#(
    parameter int unsigned VISIBLE_LINES = 144
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic                  i_cfg_wr_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [IN_TDATA_W-1:0] i_tdata,
    input  logic [IN_TUSER_W-1:0] i_tuser,
    input  logic                  i_queue_full,
    output logic                  o_push,
    output t_job                  o_job
);

    localparam logic [2:0]  PREP_CLOCKS   = 3'd4;
    localparam logic [6:0]  BURST_CLK_SS  = 7'(4 + BLOCK_BYTES * 2);
    localparam logic [6:0]  BURST_CLK_DS  = 7'(4 + BLOCK_BYTES * 4);
    localparam logic [11:0] BLOCK_BYTES12 = 12'(BLOCK_BYTES);

    function automatic logic [7:0] readback_of(input logic [11:0] bytes);
        logic [11:0] dec;
        dec = bytes - 12'd1;
        return (bytes != 12'd0) ? dec[11:4] : READBACK_IDLE;
    endfunction

    logic        w_action;
    logic [2:0]  w_sel;
    logic [7:0]  w_val;
    logic        w_halted;
    logic        w_lcd;
    logic [7:0]  w_line;
    logic        w_hready;

    assign w_action = i_tuser[0];
    assign w_sel    = i_tuser[3:1];
    assign w_val    = i_tdata[7:0];
    assign w_halted = i_tdata[8];
    assign w_lcd    = i_tdata[9];
    assign w_line   = i_tdata[17:10];
    assign w_hready = i_tdata[18];

    t_mode       r_mode, n_mode;
    logic [15:0] r_src, n_src;
    logic [12:0] r_dst, n_dst;
    logic [11:0] r_bytes, n_bytes;
    logic [2:0]  r_prep, n_prep;
    logic [13:0] r_cclk, n_cclk;
    logic [7:0]  r_readback, n_readback;
    logic [8:0]  r_last_line, n_last_line;
    logic        r_double_speed;

    logic [7:0]  w_blocks;
    logic [13:0] w_cclk_dec;
    logic        w_moved;
    logic [11:0] w_bytes_mv;
    logic [8:0]  w_cur_line;

    assign o_ready    = !i_queue_full;
    assign o_push     = i_valid && o_ready;

    assign w_blocks   = {1'b0, w_val[6:0]} + 8'd1;
    assign w_cclk_dec = r_cclk - 14'd1;
    assign w_moved    = r_double_speed ? (w_cclk_dec[1:0] == 2'b00) : !w_cclk_dec[0];
    assign w_bytes_mv = (w_moved && r_bytes != 12'd0) ? r_bytes - 12'd1 : r_bytes;
    assign w_cur_line = w_lcd ? {1'b0, w_line} : LINE_LCD_OFF;

    always_comb begin
        n_mode      = r_mode;
        n_src       = r_src;
        n_dst       = r_dst;
        n_bytes     = r_bytes;
        n_prep      = r_prep;
        n_cclk      = r_cclk;
        n_readback  = r_readback;
        n_last_line = r_last_line;
        o_job       = '0;

        if (w_action == ACT_WRITE) begin
            case (w_sel)
                SEL_SRC_HI: n_src = {w_val, r_src[7:0]};
                SEL_SRC_LO: n_src = {r_src[15:8], w_val[7:4], 4'b0000};
                SEL_DST_HI: n_dst = {w_val[4:0], r_dst[7:0]};
                SEL_DST_LO: n_dst = {r_dst[12:8], w_val[7:4], 4'b0000};
                SEL_CONTROL: begin
                    if (r_mode == MODE_IDLE || w_val[7]) begin
                        n_bytes = {w_blocks, 4'b0000};
                        if (w_val[7]) begin
                            n_mode      = MODE_HBLANK;
                            n_readback  = {1'b0, w_val[6:0]};
                            n_prep      = 3'd0;
                            n_last_line = LINE_NONE;
                        end else begin
                            n_mode     = MODE_GENERAL;
                            n_readback = w_val;
                            n_prep     = PREP_CLOCKS;
                            n_cclk     = r_double_speed ? {w_blocks, 6'b0} : {1'b0, w_blocks, 5'b0};
                        end
                    end else begin
                        n_bytes     = 12'd0;
                        n_last_line = LINE_NONE;
                        n_mode      = MODE_IDLE;
                        n_readback  = w_val | 8'h80;
                    end
                end
                default: ;
            endcase
            o_job.src = n_src;
            o_job.dst = n_dst;
        end else begin
            o_job.src = r_src;
            o_job.dst = r_dst;
            if (!w_halted) begin
                case (r_mode)
                    MODE_GENERAL: begin
                        if (r_prep != 3'd0) begin
                            n_prep       = r_prep - 3'd1;
                            o_job.clocks = 7'd1;
                        end else if (r_cclk != 14'd0) begin
                            n_cclk           = w_cclk_dec;
                            o_job.clocks     = 7'd1;
                            o_job.copy_valid = w_moved;
                            n_bytes          = w_bytes_mv;
                            if (w_moved) begin
                                n_src = r_src + 16'd1;
                                n_dst = r_dst + 13'd1;
                                if (w_bytes_mv == 12'd0) begin
                                    n_mode = MODE_IDLE;
                                end
                            end
                            // Clock budget ran out with bytes left: the copy is dropped.
                            if (w_cclk_dec == 14'd0 && w_bytes_mv != 12'd0) begin
                                n_bytes = 12'd0;
                                n_mode  = MODE_IDLE;
                            end
                            n_readback = readback_of(n_bytes);
                        end else begin
                            n_bytes    = 12'd0;
                            n_mode     = MODE_IDLE;
                            n_readback = READBACK_IDLE;
                        end
                    end
                    MODE_HBLANK: begin
                        if (r_last_line != w_cur_line && (!w_lcd || w_hready)) begin
                            n_last_line = w_cur_line;
                            if (!w_lcd || {1'b0, w_line} < 9'(VISIBLE_LINES)) begin
                                o_job.copy_valid = 1'b1;
                                o_job.burst      = 1'b1;
                                o_job.clocks     = r_double_speed ? BURST_CLK_DS : BURST_CLK_SS;
                                n_src            = r_src + 16'(BLOCK_BYTES);
                                n_dst            = r_dst + 13'(BLOCK_BYTES);
                                if (r_bytes <= BLOCK_BYTES12) begin
                                    n_bytes     = 12'd0;
                                    n_mode      = MODE_IDLE;
                                    n_last_line = LINE_NONE;
                                    n_readback  = READBACK_IDLE;
                                end else begin
                                    n_bytes    = r_bytes - BLOCK_BYTES12;
                                    n_readback = readback_of(r_bytes - BLOCK_BYTES12);
                                end
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end

        o_job.status = n_readback;
        o_job.mode   = n_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= MODE_IDLE;
            r_src          <= '0;
            r_dst          <= '0;
            r_bytes        <= '0;
            r_prep         <= '0;
            r_cclk         <= '0;
            r_readback     <= READBACK_IDLE;
            r_last_line    <= LINE_NONE;
            r_double_speed <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_double_speed <= i_cfg_wr_data;
            end
            if (o_push) begin
                r_mode      <= n_mode;
                r_src       <= n_src;
                r_dst       <= n_dst;
                r_bytes     <= n_bytes;
                r_prep      <= n_prep;
                r_cclk      <= n_cclk;
                r_readback  <= n_readback;
                r_last_line <= n_last_line;
            end
        end
    end

endmodule

[hw/rtl/vhdma_fifo.sv]
// Short job queue between the front and back ends of the VRAM DMA unit.
// Depends on vhdma_pkg for the t_job entry type.
module vhdma_fifo
    import vhdma_pkg::*;
#(
    parameter int unsigned DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_push_data,
    output logic o_full,
    input  logic i_pop,
    output t_job o_pop_data,
    output logic o_empty
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push, w_pop;

    assign o_full     = (r_count == CNT_W'(DEPTH));
    assign o_empty    = (r_count == '0);
    assign w_push     = i_push && !o_full;
    assign w_pop      = i_pop && !o_empty;
    assign o_pop_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[hw/rtl/vhdma_back.sv]
// Back end of the VRAM DMA unit: expands queued jobs into result items.
// Depends on vhdma_pkg; drains the job queue into a registered output stage.
module vhdma_back
    import vhdma_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_job                   i_job,
    input  logic                   i_job_empty,
    output logic                   o_pop,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [OUT_TDATA_W-1:0] o_tdata,
    output logic [OUT_TUSER_W-1:0] o_tuser,
    output logic                   o_tlast
);

    localparam logic [2:0] VRAM_BASE_HI = 3'b100;

    logic [BEAT_W-1:0] r_beat;
    logic              r_valid;
    logic [15:0]       r_src;
    logic [15:0]       r_dst;
    logic [7:0]        r_status;
    logic [6:0]        r_clocks;
    logic              r_copy_valid;
    t_mode             r_mode;
    logic              r_last;

    logic              w_load;
    logic              w_final;
    logic [12:0]       w_dst_off;

    assign w_load    = !i_job_empty && (!r_valid || i_ready);
    assign w_final   = !i_job.burst || (r_beat == BEAT_W'(BLOCK_BYTES - 1));
    assign w_dst_off = i_job.dst + 13'(r_beat);
    assign o_pop     = w_load && w_final;

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_src        <= i_job.src + 16'(r_beat);
            r_dst        <= {VRAM_BASE_HI, w_dst_off};
            r_status     <= i_job.status;
            r_clocks     <= w_final ? i_job.clocks : 7'd0;
            r_copy_valid <= i_job.copy_valid;
            r_mode       <= i_job.mode;
            r_last       <= w_final;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_beat  <= '0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
                r_beat  <= w_final ? '0 : r_beat + 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_tdata = {1'b0, r_clocks, r_status, r_dst, r_src};
    assign o_tuser = {r_mode, r_copy_valid};
    assign o_tlast = r_last;

endmodule

[hw/rtl/vram_general_hblank_dma_unit.sv]
// Channel   | Direction | Contents
// s_axis    | in        | one register write or one clock step / line check per item
// m_axis    | out       | result items: a byte copy or a status-only report
// cfg       | in        | double speed flag, one write-only bit
//
// An input item is taken while the job queue has room; the front end updates
// the copy state and queues one job. A job gives one result item, or sixteen
// for an h-blank burst. The front end keeps taking items until the job queue
// (QUEUE_DEPTH entries) fills. Reset is synchronous and active low; there is
// no clearing pass, so items are taken from the first cycle after reset. A
// stall on the output only fills the queue.
//
// Top level of the VRAM DMA unit. Depends on vhdma_pkg, vhdma_front, vhdma_fifo,
// vhdma_back and the assertion macros header.
`include "vram_general_hblank_dma_unit_macros.svh"

module vram_general_hblank_dma_unit
    import vhdma_pkg::*;
#(
    parameter int unsigned VISIBLE_LINES = 144,
    parameter int unsigned QUEUE_DEPTH   = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Configuration: bit 0 of the data is the double speed flag.
    input  logic                   i_cfg_wr_en,
    input  logic                   i_cfg_wr_data,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // From bit 0: write_value[7:0], cpu_halted, lcd_on, line[7:0], hblank_ready, zero pad.
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // From bit 0: action, reg_select[2:0].
    input  logic [IN_TUSER_W-1:0]  i_s_axis_tuser,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // From bit 0: src_addr[15:0], dst_addr[15:0], status[7:0], clocks_used[6:0], zero pad.
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    // From bit 0: copy_valid, mode[1:0].
    output logic [OUT_TUSER_W-1:0] o_m_axis_tuser,
    // Marks the final result item caused by one input item.
    output logic                   o_m_axis_tlast
);

    // The front end pushes into the queue; the back end pops a job once all
    // of its result items have entered the output register.
    t_job w_push_job;
    t_job w_head_job;
    logic w_push;
    logic w_pop;
    logic w_full;
    logic w_empty;

    vhdma_front #(
        .VISIBLE_LINES (VISIBLE_LINES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_s_axis_tvalid),
        .o_ready       (o_s_axis_tready),
        .i_tdata       (i_s_axis_tdata),
        .i_tuser       (i_s_axis_tuser),
        .i_queue_full  (w_full),
        .o_push        (w_push),
        .o_job         (w_push_job)
    );

    vhdma_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_job),
        .o_full      (w_full),
        .i_pop       (w_pop),
        .o_pop_data  (w_head_job),
        .o_empty     (w_empty)
    );

    // The back end walks an h-blank job one byte per cycle while not stalled, adding
    // the beat index to the job's start pointers, and registers each result item.
    vhdma_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (w_head_job),
        .i_job_empty (w_empty),
        .o_pop       (w_pop),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_tdata     (o_m_axis_tdata),
        .o_tuser     (o_m_axis_tuser),
        .o_tlast     (o_m_axis_tlast)
    );

    // The front end only pushes when the queue has room.
    `VHDMA_ASSERT_IMPLY(a_push_has_room, i_clk, i_rst_n, w_push, !w_full, "push into full queue")
    // A pop never happens on an empty queue.
    `VHDMA_ASSERT_IMPLY(a_pop_not_empty, i_clk, i_rst_n, w_pop, !w_empty, "pop from empty queue")
    // Every destination address lies inside the VRAM window.
    `VHDMA_ASSERT_IMPLY(a_dst_in_vram, i_clk, i_rst_n, o_m_axis_tvalid,
        o_m_axis_tdata[31:29] == 3'b100, "destination outside VRAM")
    // Only the final result item of an input item reports clocks.
    `VHDMA_ASSERT_IMPLY(a_clocks_on_last, i_clk, i_rst_n, o_m_axis_tvalid && !o_m_axis_tlast,
        o_m_axis_tdata[46:40] == 7'd0, "clocks on a non-final item")

endmodule

[sim/vram_general_hblank_dma_unit_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the VRAM DMA unit: it streams register writes and clock steps,
// predicts every result item in place and compares them field by field as they arrive.
// Depends on vhdma_pkg and the vram_general_hblank_dma_unit RTL.
module vram_general_hblank_dma_unit_tb
    import vhdma_pkg::*;
();

    // Lines below this number are drawn lines that can earn an h-blank burst.
    localparam int unsigned LINES_SHOWN   = 144;
    // Selector codes that address no register at all.
    localparam logic [2:0]  SEL_UNUSED_LO = 3'd5;
    localparam logic [2:0]  SEL_UNUSED_HI = 3'd7;
    // Cycles to let pass after the last result before a speed change or the end of the run.
    localparam int unsigned SETTLE_CYCLES = 24;
    // Cycles with no accepted item, no speed write and no reset before the run is abandoned.
    localparam int unsigned QUIET_LIMIT   = 1000;

    // One result item as the unit should present it.
    typedef struct {
        logic        copy_valid;
        logic [15:0] src;
        logic [15:0] dst;
        logic        last;
        logic [7:0]  status;
        t_mode       mode;
        logic [6:0]  clocks;
    } t_dma_result;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic                   cfg_wr_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic [IN_TUSER_W-1:0]  s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [OUT_TUSER_W-1:0] m_tuser;
    logic                   m_tlast;

    // Run control shared by the processes below.
    bit          bursty;
    int unsigned sink_hold;
    int unsigned errors;
    int unsigned quiet;

    // Results still owed by the unit, oldest first.
    t_dma_result pending_results[$];
    t_dma_result oldest;

    // Mirror of the unit's copy state and of the double speed flag.
    t_mode       dma_mode;
    logic [15:0] src_ptr;
    logic [12:0] dst_ptr;
    int unsigned bytes_left;
    int unsigned prep_left;
    int unsigned budget_left;
    logic [7:0]  ctrl_readback;
    logic [8:0]  served_line;
    logic        double_speed;

    // Copy and pointer snapshots gathered while one item is predicted.
    logic        beat_copy [BLOCK_BYTES];
    logic [15:0] beat_src  [BLOCK_BYTES];
    logic [15:0] beat_dst  [BLOCK_BYTES];
    int unsigned beat_count;

    vram_general_hblank_dma_unit dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    // 10 ns clock.
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Copy-state predictor
    // ------------------------------------------------------------------

    function automatic void reset_copy_state();
        dma_mode      = MODE_IDLE;
        src_ptr       = 16'h0000;
        dst_ptr       = 13'h0000;
        bytes_left    = 0;
        prep_left     = 0;
        budget_left   = 0;
        ctrl_readback = READBACK_IDLE;
        served_line   = LINE_NONE;
        double_speed  = 1'b0;
    endfunction

    // Records one result's copy flag and the pointers as they stand right now.
    function automatic void capture_beat(logic moved);
        beat_copy[beat_count] = moved;
        beat_src[beat_count]  = src_ptr;
        beat_dst[beat_count]  = {3'b100, dst_ptr};
        beat_count++;
    endfunction

    // The source wraps at 16 bits; the destination wraps inside the 8 KiB window.
    function automatic void advance_ptrs();
        src_ptr = src_ptr + 16'd1;
        dst_ptr = dst_ptr + 13'd1;
    endfunction

    // Readback shows the remaining blocks minus one, or all ones once nothing is left.
    function automatic void refresh_readback();
        ctrl_readback = (bytes_left != 0) ? 8'((bytes_left - 1) / BLOCK_BYTES) : READBACK_IDLE;
    endfunction

    function automatic void begin_copy(logic [7:0] value);
        int unsigned blocks;
        blocks     = value[6:0] + 1;
        bytes_left = blocks * BLOCK_BYTES;
        if (value[7]) begin
            dma_mode      = MODE_HBLANK;
            ctrl_readback = {1'b0, value[6:0]};
            prep_left     = 0;
            served_line   = LINE_NONE;
        end else begin
            dma_mode      = MODE_GENERAL;
            ctrl_readback = value;
            prep_left     = 4;
            budget_left   = blocks * (double_speed ? 64 : 32);
        end
    endfunction

    // Works out every result item that one accepted input item causes and queues them.
    function automatic void predict_item(logic act, logic [2:0] sel, logic [7:0] val,
                                         logic halted, logic lcd, logic [7:0] line,
                                         logic ready);
        int unsigned spent;
        int unsigned mask;
        logic [8:0]  cur;
        t_dma_result r;
        beat_count = 0;
        spent      = 0;
        if (act == ACT_WRITE) begin
            case (sel)
                SEL_SRC_HI: src_ptr = {val, src_ptr[7:0]};
                SEL_SRC_LO: src_ptr = {src_ptr[15:8], val[7:4], 4'h0};
                SEL_DST_HI: dst_ptr = {val[4:0], dst_ptr[7:0]};
                SEL_DST_LO: dst_ptr = {dst_ptr[12:8], val[7:4], 4'h0};
                SEL_CONTROL: begin
                    if (dma_mode == MODE_IDLE || val[7]) begin
                        begin_copy(val);
                    end else begin
                        // Stop command: the copy is dropped and bit 7 flags the stop.
                        bytes_left    = 0;
                        served_line   = LINE_NONE;
                        dma_mode      = MODE_IDLE;
                        ctrl_readback = val | 8'h80;
                    end
                end
                default: ;
            endcase
            capture_beat(1'b0);
        end else if (halted || dma_mode == MODE_IDLE) begin
            capture_beat(1'b0);
        end else if (dma_mode == MODE_GENERAL) begin
            if (prep_left > 0) begin
                prep_left--;
                spent = 1;
                capture_beat(1'b0);
            end else if (budget_left > 0) begin
                mask = double_speed ? 3 : 1;
                budget_left--;
                spent = 1;
                if ((budget_left & mask) == 0) begin
                    capture_beat(1'b1);
                    advance_ptrs();
                    if (bytes_left > 0)
                        bytes_left--;
                    if (bytes_left == 0)
                        dma_mode = MODE_IDLE;
                end else begin
                    capture_beat(1'b0);
                end
                // A speed change in mid-copy can run the clock budget dry with bytes left.
                if (budget_left == 0 && bytes_left > 0) begin
                    bytes_left = 0;
                    dma_mode   = MODE_IDLE;
                end
                refresh_readback();
            end else begin
                bytes_left    = 0;
                dma_mode      = MODE_IDLE;
                ctrl_readback = READBACK_IDLE;
                capture_beat(1'b0);
            end
        end else begin
            cur = lcd ? {1'b0, line} : LINE_LCD_OFF;
            if (served_line != cur && (!lcd || ready)) begin
                served_line = cur;
                if (!lcd || line < LINES_SHOWN) begin
                    repeat (BLOCK_BYTES) begin
                        capture_beat(1'b1);
                        advance_ptrs();
                    end
                    spent = 4 + BLOCK_BYTES * (double_speed ? 4 : 2);
                    if (bytes_left <= BLOCK_BYTES) begin
                        bytes_left    = 0;
                        dma_mode      = MODE_IDLE;
                        served_line   = LINE_NONE;
                        ctrl_readback = READBACK_IDLE;
                    end else begin
                        bytes_left -= BLOCK_BYTES;
                        refresh_readback();
                    end
                end
            end
            if (beat_count == 0)
                capture_beat(1'b0);
        end
        // Status, mode and clock count reflect the state after the whole item.
        for (int unsigned k = 0; k < beat_count; k++) begin
            r.copy_valid = beat_copy[k];
            r.src        = beat_src[k];
            r.dst        = beat_dst[k];
            r.last       = (k == beat_count - 1);
            r.status     = ctrl_readback;
            r.mode       = dma_mode;
            r.clocks     = r.last ? 7'(spent) : 7'd0;
            pending_results.push_back(r);
        end
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endfunction

    // Every accepted result item is matched against the oldest outstanding prediction.
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t ns: unexpected result item, expected none, actual tdata %h tuser %h",
                         $time, m_tdata, m_tuser);
            end else begin
                oldest = pending_results.pop_front();
                compare_field("copy_valid", 16'(oldest.copy_valid), 16'(m_tuser[0]));
                compare_field("src_addr", oldest.src, m_tdata[15:0]);
                compare_field("dst_addr", oldest.dst, m_tdata[31:16]);
                compare_field("last", 16'(oldest.last), 16'(m_tlast));
                compare_field("status", 16'(oldest.status), 16'(m_tdata[39:32]));
                compare_field("mode", 16'(oldest.mode), 16'(m_tuser[2:1]));
                compare_field("clocks_used", 16'(oldest.clocks), 16'(m_tdata[46:40]));
            end
        end
    end

    // The result side stalls at random while bursty idling is on.
    always @(negedge clk) begin
        if (!rst_n) begin
            m_tready = 1'b0;
        end else if (sink_hold > 0) begin
            sink_hold--;
            m_tready = 1'b0;
        end else if (bursty && $urandom_range(0, 4) == 0) begin
            sink_hold = $urandom_range(0, 3);
            m_tready  = 1'b0;
        end else begin
            m_tready = 1'b1;
        end
    end

    // Watchdog: the run is abandoned after a long stretch in which nothing moves.
    initial begin
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if (!rst_n || cfg_wr_en || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t ns: watchdog expired with %0d results outstanding",
                 $time, pending_results.size());
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offers one item from the falling edge, holds it until accepted, then predicts it.
    task automatic send_item(input logic act, input logic [2:0] sel, input logic [7:0] val,
                             input logic halted, input logic lcd, input logic [7:0] line,
                             input logic ready);
        @(negedge clk);
        if (bursty && $urandom_range(0, 3) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        s_tdata  = {5'd0, ready, line, lcd, halted, val};
        s_tuser  = {sel, act};
        s_tvalid = 1'b1;
        do @(posedge clk); while (!s_tready);
        predict_item(act, sel, val, halted, lcd, line, ready);
    endtask

    // Register write; the fields a write ignores carry random values.
    task automatic send_write(input logic [2:0] sel, input logic [7:0] val);
        send_item(ACT_WRITE, sel, val, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  8'($urandom_range(0, 153)), 1'($urandom_range(0, 1)));
    endtask

    // Clock step or line check; the write fields carry random values.
    task automatic send_step(input logic halted, input logic lcd, input logic [7:0] line,
                             input logic ready);
        send_item(ACT_STEP, 3'($urandom_range(0, 4)), 8'($urandom), halted, lcd, line, ready);
    endtask

    // A general step that is rarely halted and has random display fields.
    task automatic send_clock();
        send_step(1'($urandom_range(0, 7) == 0), 1'($urandom_range(0, 1)),
                  8'($urandom_range(0, 153)), 1'($urandom_range(0, 1)));
    endtask

    // Holds off the sender until every predicted result has come out, then lets it settle.
    task automatic wait_drained();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // The speed flag is only written once the unit has nothing in flight.
    task automatic set_double_speed(input logic value);
        wait_drained();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge clk);
        cfg_wr_en    = 1'b0;
        double_speed = value;
    endtask

    task automatic load_pointers();
        send_write(SEL_SRC_HI, 8'($urandom));
        send_write(SEL_SRC_LO, 8'($urandom));
        send_write(SEL_DST_HI, 8'($urandom));
        send_write(SEL_DST_LO, 8'($urandom));
    endtask

    // Starts a copy; before a general start, any busy copy is stopped so the command is a start.
    task automatic launch(input logic [7:0] ctrl);
        if (dma_mode != MODE_IDLE && !ctrl[7])
            send_write(SEL_CONTROL, 8'h00);
        send_write(SEL_CONTROL, ctrl);
    endtask

    // Line checks for a running h-blank copy: lines mostly advance in order, with the
    // display sometimes off, the CPU sometimes halted and stray pointer writes now and then.
    task automatic run_hblank(input int unsigned max_items, input bit pause_midway);
        logic [7:0]  line;
        int unsigned count;
        int unsigned pick;
        line  = 8'($urandom_range(0, 153));
        count = 0;
        while (dma_mode == MODE_HBLANK && count < max_items) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                send_write(3'($urandom_range(SEL_SRC_HI, SEL_DST_LO)), 8'($urandom));
            end else if (pick <= 2) begin
                send_step(1'b0, 1'b0, 8'($urandom), 1'($urandom_range(0, 1)));
            end else if (pick == 3) begin
                send_step(1'b1, 1'b1, line, 1'b1);
            end else begin
                if ($urandom_range(0, 1) == 0)
                    line = (line >= 153) ? 8'd0 : line + 8'd1;
                send_step(1'b0, 1'b1, line, 1'($urandom_range(0, 3) != 0));
            end
            count++;
            if (pause_midway && count == max_items / 2)
                wait_drained();
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Register extremes, unused selectors, start, stop and restart commands, the halted
    // CPU, the display-off burst, lines past the visible area and the final burst.
    task automatic test_directed();
        set_double_speed(1'b0);
        send_write(SEL_SRC_HI, 8'hFF);
        send_write(SEL_SRC_LO, 8'hFF);
        send_write(SEL_DST_HI, 8'hFF);
        send_write(SEL_DST_LO, 8'hFF);
        send_write(SEL_UNUSED_LO, 8'h00);
        send_write(SEL_UNUSED_HI, 8'hAA);
        send_step(1'b0, 1'b1, 8'd0, 1'b1);
        send_write(SEL_CONTROL, 8'h00);
        send_step(1'b1, 1'b1, 8'd5, 1'b0);
        repeat (6) send_step(1'b0, 1'b0, 8'd0, 1'b0);
        send_write(SEL_CONTROL, 8'h05);
        send_write(SEL_CONTROL, 8'h80);
        send_step(1'b0, 1'b1, 8'd10, 1'b0);
        send_step(1'b0, 1'b1, 8'd150, 1'b1);
        send_step(1'b0, 1'b1, 8'd150, 1'b1);
        send_write(SEL_CONTROL, 8'h81);
        send_step(1'b0, 1'b0, 8'd0, 1'b0);
        send_step(1'b0, 1'b0, 8'd77, 1'b1);
        send_step(1'b0, 1'b1, 8'd153, 1'b1);
        send_step(1'b0, 1'b1, 8'd143, 1'b1);
        send_write(SEL_CONTROL, 8'hFF);
        send_write(SEL_CONTROL, 8'h7F);
        send_write(SEL_DST_HI, 8'h00);
        send_write(SEL_SRC_LO, 8'h00);
    endtask

    // Whole general copies at both speeds, and one stopped part way.
    task automatic test_general_copy();
        set_double_speed(1'b0);
        load_pointers();
        launch(8'h00);
        while (dma_mode == MODE_GENERAL) send_clock();
        set_double_speed(1'b1);
        load_pointers();
        launch(8'h00);
        while (dma_mode == MODE_GENERAL) send_clock();
        launch(8'($urandom_range(0, 127)));
        repeat ($urandom_range(4, 16)) send_clock();
        send_write(SEL_CONTROL, 8'($urandom_range(0, 127)));
    endtask

    // Speed changes in mid-copy: the slower rate runs out of clocks with bytes left,
    // the faster rate finishes the bytes before the clocks.
    task automatic test_speed_switch();
        set_double_speed(1'b0);
        load_pointers();
        launch(8'h00);
        repeat (12) send_step(1'b0, 1'b1, 8'd0, 1'b0);
        set_double_speed(1'b1);
        while (dma_mode == MODE_GENERAL) send_clock();
        load_pointers();
        launch(8'h00);
        repeat (12) send_step(1'b0, 1'b1, 8'd0, 1'b0);
        set_double_speed(1'b0);
        while (dma_mode == MODE_GENERAL) send_clock();
    endtask

    // H-blank copies of a few blocks at both speeds; the sender waits out the results once.
    task automatic test_hblank_copy();
        set_double_speed(1'b0);
        load_pointers();
        launch({1'b1, 7'($urandom_range(1, 5))});
        run_hblank(60, 1'b1);
        set_double_speed(1'b1);
        load_pointers();
        launch({1'b1, 7'($urandom_range(1, 5))});
        run_hblank(60, 1'b0);
    endtask

    // Unordered items of every kind, including random control values.
    task automatic test_register_noise();
        repeat (50) begin
            send_item(1'($urandom_range(0, 1)), 3'($urandom_range(0, 4)), 8'($urandom),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      8'($urandom_range(0, 153)), 1'($urandom_range(0, 1)));
        end
        if (dma_mode == MODE_GENERAL)
            send_write(SEL_CONTROL, 8'h00);
    endtask

    // Back-to-back traffic with no idling on either side.
    task automatic test_steady_stream();
        bursty = 1'b0;
        set_double_speed(1'($urandom_range(0, 1)));
        load_pointers();
        launch({1'b1, 7'($urandom_range(1, 3))});
        run_hblank(40, 1'b0);
        load_pointers();
        launch(8'h00);
        while (dma_mode == MODE_GENERAL) send_clock();
    endtask

    initial begin
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        m_tready    = 1'b0;
        bursty      = 1'b1;
        sink_hold   = 0;
        errors      = 0;
        reset_copy_state();
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_general_copy();
        test_speed_switch();
        test_hblank_copy();
        test_register_noise();
        test_steady_stream();

        wait_drained();
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
